[rtl/slrd_pkg.sv]
// Package with the shared types and constants of the shuffled range draw core.
package slrd_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int WARM_SKIP     = 8;
    localparam int WARM_STEPS    = TABLE_ENTRIES + WARM_SKIP;
    localparam int CNT_W         = $clog2(WARM_STEPS);
    localparam int DRAW_W        = 31;
    localparam int DCNT_W        = $clog2(DRAW_W);

    localparam logic [14:0] LCG_MUL = 15'd16807;
    localparam logic [30:0] LCG_MOD = 31'h7FFF_FFFF;
    localparam logic [30:0] BUCKET  = 31'(1 + (2147483647 - 1) / TABLE_ENTRIES);

    typedef logic [DRAW_W-1:0] t_draw;
    typedef logic signed [31:0] t_value;

endpackage

[rtl/slrd_if.sv]
// Valid/ready channel interfaces for requests and results of the range draw core.
interface slrd_req_if;
    logic            valid;
    logic            ready;
    slrd_pkg::t_value range_low;
    slrd_pkg::t_value range_high;

    modport source (output valid, output range_low, output range_high, input ready);
    modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

interface slrd_rsp_if;
    logic            valid;
    logic            ready;
    slrd_pkg::t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[rtl/shuffled_lcg_range_draw_core.sv]
// Top level of the shuffled minimal-standard generator with unbiased range draw.
// A degenerate span goes from acceptance straight to the output state and the result register.
// A draw runs through read, update, a 31-step remainder, check and output, preceded by a
// warm-up when one is needed and repeated from the read for each rejected draw. Requests
// are taken only in the idle state. The result register lets the next request in early.
// Reset is synchronous and active low; the shuffle table needs no clearing pass.
module shuffled_lcg_range_draw_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_seed_we,
    input  slrd_pkg::t_value i_seed,
    slrd_req_if.sink         i_req,
    slrd_rsp_if.source       o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WARM = 3'd1;
    localparam logic [2:0] S_DRAW = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    function automatic slrd_pkg::t_draw lcg_next(input slrd_pkg::t_draw s);
        logic [45:0] p;
        logic [31:0] r;
        p = 46'(s) * 46'(slrd_pkg::LCG_MUL);
        r = 32'(p[45:31]) + 32'(p[30:0]);
        if (r >= 32'(slrd_pkg::LCG_MOD)) begin
            r = r - 32'(slrd_pkg::LCG_MOD);
        end
        return r[30:0];
    endfunction

    logic [2:0]                      r_state, n_state;
    slrd_pkg::t_draw                 r_lcg, n_lcg;
    slrd_pkg::t_draw                 r_shuf, n_shuf;
    logic                            r_warm, n_warm;
    logic [slrd_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [slrd_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [31:0]                     r_low, n_low;
    logic [31:0]                     r_span, n_span;
    slrd_pkg::t_draw                 r_num, n_num;
    logic [31:0]                     r_rem, n_rem;
    logic [slrd_pkg::DCNT_W-1:0]     r_dcnt, n_dcnt;
    logic [31:0]                     r_res, n_res;
    logic                            r_out_valid, n_out_valid;
    logic [31:0]                     r_out_value, n_out_value;

    slrd_pkg::t_draw                 r_table [slrd_pkg::TABLE_ENTRIES];
    slrd_pkg::t_draw                 r_rdata;
    logic                            mem_we;
    logic                            mem_re;
    logic [slrd_pkg::IDX_W-1:0]      mem_wa;
    logic [slrd_pkg::IDX_W-1:0]      mem_ra;
    slrd_pkg::t_draw                 mem_wd;

    slrd_pkg::t_draw                 lcg_step;
    logic                            warm_go;
    slrd_pkg::t_draw                 warm_start;
    slrd_pkg::t_draw                 bucket_q;
    logic [slrd_pkg::IDX_W-1:0]      draw_idx;
    logic [31:0]                     span_m1;
    logic [32:0]                     rem_sh;
    logic [32:0]                     chk_sum;
    logic [31:0]                     seed_mag;
    logic [slrd_pkg::CNT_W-1:0]      warm_pos;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.value = r_out_value;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_table[mem_ra];
        end
    end

    always_comb begin
        lcg_step   = lcg_next(r_lcg);
        warm_go    = r_warm || (r_shuf == '0) || (r_lcg == '0);
        warm_start = r_warm ? r_lcg : 31'd1;
        if (warm_start == '0) begin
            warm_start = 31'd1;
        end
        bucket_q = r_shuf / slrd_pkg::BUCKET;
        if (bucket_q >= 31'(slrd_pkg::TABLE_ENTRIES)) begin
            draw_idx = slrd_pkg::IDX_W'(slrd_pkg::TABLE_ENTRIES - 1);
        end else begin
            draw_idx = bucket_q[slrd_pkg::IDX_W-1:0];
        end
        span_m1  = 32'(i_req.range_high) - 32'(i_req.range_low);
        rem_sh   = {r_rem, r_num[r_dcnt]};
        chk_sum  = 33'(r_num) - 33'(r_rem) + 33'(r_span);
        seed_mag = i_seed[31] ? (32'd0 - 32'(i_seed)) : 32'(i_seed);
        if (seed_mag > 32'(slrd_pkg::LCG_MOD)) begin
            seed_mag = 32'(slrd_pkg::LCG_MOD);
        end
        warm_pos = slrd_pkg::CNT_W'(slrd_pkg::WARM_STEPS - 1) - r_cnt;
    end

    always_comb begin
        n_state     = r_state;
        n_lcg       = r_lcg;
        n_shuf      = r_shuf;
        n_warm      = r_warm;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_low       = r_low;
        n_span      = r_span;
        n_num       = r_num;
        n_rem       = r_rem;
        n_dcnt      = r_dcnt;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wa      = draw_idx;
        mem_ra      = draw_idx;
        mem_wd      = lcg_step;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_low  = 32'(i_req.range_low);
                    n_span = span_m1 + 32'd1;
                    if ((span_m1 == '0) || span_m1[31]) begin
                        n_res   = 32'(i_req.range_low);
                        n_state = S_OUT;
                    end else if (warm_go) begin
                        n_lcg   = warm_start;
                        n_cnt   = '0;
                        n_state = S_WARM;
                    end else begin
                        n_state = S_DRAW;
                    end
                end
            end
            S_WARM: begin
                n_lcg  = lcg_step;
                mem_wa = warm_pos[slrd_pkg::IDX_W-1:0];
                if (r_cnt >= slrd_pkg::CNT_W'(slrd_pkg::WARM_SKIP)) begin
                    mem_we = 1'b1;
                end
                if (r_cnt == slrd_pkg::CNT_W'(slrd_pkg::WARM_STEPS - 1)) begin
                    n_shuf  = lcg_step;
                    n_warm  = 1'b0;
                    n_state = S_DRAW;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAW: begin
                n_lcg   = lcg_step;
                mem_re  = 1'b1;
                n_idx   = draw_idx;
                n_state = S_UPD;
            end
            S_UPD: begin
                mem_we  = 1'b1;
                mem_wa  = r_idx;
                mem_wd  = r_lcg;
                n_shuf  = r_rdata;
                n_num   = r_rdata;
                n_rem   = '0;
                n_dcnt  = slrd_pkg::DCNT_W'(slrd_pkg::DRAW_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, r_span}) begin
                    n_rem = 32'(rem_sh - {1'b0, r_span});
                end else begin
                    n_rem = rem_sh[31:0];
                end
                if (r_dcnt == '0) begin
                    n_state = S_CHK;
                end else begin
                    n_dcnt = r_dcnt - 1'b1;
                end
            end
            S_CHK: begin
                if (chk_sum <= 33'h0_8000_0000) begin
                    n_res   = r_low + r_rem;
                    n_state = S_OUT;
                end else if (warm_go) begin
                    n_lcg   = warm_start;
                    n_cnt   = '0;
                    n_state = S_WARM;
                end else begin
                    n_state = S_DRAW;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_seed_we) begin
            n_lcg  = seed_mag[30:0];
            n_shuf = '0;
            n_warm = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lcg       <= '0;
            r_shuf      <= '0;
            r_warm      <= 1'b1;
            r_cnt       <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lcg       <= n_lcg;
            r_shuf      <= n_shuf;
            r_warm      <= n_warm;
            r_cnt       <= n_cnt;
            r_dcnt      <= n_dcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_low       <= n_low;
        r_span      <= n_span;
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_res       <= n_res;
        r_out_value <= n_out_value;
    end

endmodule

[verif/shuffled_lcg_range_draw_core_tb.sv]
// Self-checking testbench that drives range requests into the draw core and checks results.
`timescale 1ns / 100ps

module shuffled_lcg_range_draw_core_tb;

    localparam int unsigned ITEMS_PER_PHASE = 90;
    localparam int unsigned PHASES          = 7;
    localparam int unsigned HOLD_AT         = 200;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned STALL_LIMIT     = 4000;
    localparam int unsigned DRAIN_CYCLES    = 200;
    localparam int unsigned DIR_ROWS        = 23;

    typedef struct packed {
        logic             set_seed;
        slrd_pkg::t_value seed;
        slrd_pkg::t_value lo;
        slrd_pkg::t_value hi;
        logic             known;
        slrd_pkg::t_value want;
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_seed_we;
    slrd_pkg::t_value i_seed;

    slrd_req_if req_ch ();
    slrd_rsp_if rsp_ch ();

    shuffled_lcg_range_draw_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_seed_we(i_seed_we),
        .i_seed   (i_seed),
        .i_req    (req_ch),
        .o_rsp    (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    slrd_pkg::t_draw  gen_state;
    slrd_pkg::t_draw  shuf_last;
    slrd_pkg::t_draw  shuf_tab [slrd_pkg::TABLE_ENTRIES];
    bit               warm_pending;
    slrd_pkg::t_value pending_values [$];
    int unsigned      failures    = 0;
    int unsigned      values_seen = 0;
    int unsigned      stall_cycles = 0;
    bit               no_gaps     = 1'b0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{1'b0, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{1'b0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
        '{1'b0, 32'h0, 32'h0000_000A, 32'h0000_0003, 1'b1, 32'h0000_000A},
        '{1'b0, 32'h0, 32'h8000_0000, 32'h0000_0001, 1'b1, 32'h8000_0000},
        '{1'b0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{1'b0, 32'h0, 32'h0000_0064, 32'h0000_0063, 1'b1, 32'h0000_0064},
        '{1'b0, 32'h0, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0},
        '{1'b0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{1'b0, 32'h0, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{1'b0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0},
        '{1'b0, 32'h0, 32'h0000_0000, 32'h4000_0000, 1'b0, 32'h0},
        '{1'b0, 32'h0, 32'hFFFF_FFFB, 32'h0000_0005, 1'b0, 32'h0},
        '{1'b0, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFE, 1'b0, 32'h0},
        '{1'b1, 32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_0064, 1'b1, 32'h0000_0005},
        '{1'b0, 32'h0, 32'h0000_0005, 32'h0000_0064, 1'b0, 32'h0},
        '{1'b1, 32'h8000_0000, 32'hFFFF_FFF9, 32'h0000_0007, 1'b1, 32'hFFFF_FFF9},
        '{1'b0, 32'h0, 32'hFFFF_FFF9, 32'h0000_0007, 1'b0, 32'h0},
        '{1'b1, 32'h8000_0001, 32'h0000_03E8, 32'h0000_07D0, 1'b1, 32'h0000_03E8},
        '{1'b1, 32'h0000_0001, 32'h0000_0000, 32'h0000_0009, 1'b0, 32'h0},
        '{1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0009, 1'b0, 32'h0},
        '{1'b0, 32'h0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0},
        '{1'b1, 32'h0, 32'hAAAA_AAAA, 32'hD555_5555, 1'b0, 32'h0},
        '{1'b0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF}
    };

    function automatic slrd_pkg::t_draw minstd_next(slrd_pkg::t_draw s);
        logic [63:0] prod;
        prod = 64'(s) * 64'(slrd_pkg::LCG_MUL);
        return 31'(prod % 64'(slrd_pkg::LCG_MOD));
    endfunction

    function automatic void load_seed(slrd_pkg::t_value s);
        logic [31:0] mag;
        mag = s[31] ? 32'd0 - $unsigned(s) : $unsigned(s);
        if (mag > 32'(slrd_pkg::LCG_MOD)) begin
            mag = 32'(slrd_pkg::LCG_MOD);
        end
        gen_state = mag[30:0];
        shuf_last = '0;
        foreach (shuf_tab[i]) begin
            shuf_tab[i] = '0;
        end
        warm_pending = 1'b1;
    endfunction

    function automatic slrd_pkg::t_draw shuffled_draw();
        slrd_pkg::t_draw start;
        int              j;
        int unsigned     slot;
        if (warm_pending || shuf_last == '0 || gen_state == '0) begin
            start = warm_pending ? gen_state : 31'd1;
            gen_state = (start == '0) ? 31'd1 : start;
            for (j = slrd_pkg::TABLE_ENTRIES + slrd_pkg::WARM_SKIP - 1; j >= 0; j--) begin
                gen_state = minstd_next(gen_state);
                if (j < slrd_pkg::TABLE_ENTRIES) begin
                    shuf_tab[j] = gen_state;
                end
            end
            shuf_last = shuf_tab[0];
            warm_pending = 1'b0;
        end
        gen_state = minstd_next(gen_state);
        slot = 32'(shuf_last / slrd_pkg::BUCKET);
        if (slot >= slrd_pkg::TABLE_ENTRIES) begin
            slot = slrd_pkg::TABLE_ENTRIES - 1;
        end
        shuf_last = shuf_tab[slot];
        shuf_tab[slot] = gen_state;
        return shuf_last;
    endfunction

    function automatic slrd_pkg::t_value draw_in_range(slrd_pkg::t_value lo,
                                                       slrd_pkg::t_value hi);
        logic [31:0] span;
        logic [31:0] cutoff;
        logic [31:0] n;
        span = $unsigned(hi) - $unsigned(lo) + 32'd1;
        if (span <= 32'd1 || span - 32'd1 > 32'h7FFF_FFFF) begin
            return lo;
        end
        cutoff = 32'h7FFF_FFFF - (32'h8000_0000 % span);
        do n = 32'(shuffled_draw()); while (n > cutoff);
        return $signed($unsigned(lo) + n % span);
    endfunction

    task automatic pick_range(output slrd_pkg::t_value lo, output slrd_pkg::t_value hi);
        int unsigned kind;
        int unsigned k;
        logic [31:0] span;
        kind = $urandom_range(0, 99);
        lo   = $urandom;
        if (kind < 40) begin
            span = $urandom_range(2, 64);
        end else if (kind < 65) begin
            span = $urandom_range(32'h4000_0000, 32'h8000_0000);
        end else if (kind < 77) begin
            k    = $urandom_range(1, 31);
            span = (32'd1 << k) + $urandom_range(0, 2) - 32'd1;
        end else if (kind < 85) begin
            span = $urandom_range(0, 1);
        end else if (kind < 92) begin
            span = 32'h8000_0001 + $urandom_range(0, 32'h7FFF_FFFE);
        end else begin
            span = $urandom - $unsigned(lo) + 32'd1;
        end
        hi = $signed($unsigned(lo) + span - 32'd1);
    endtask

    task automatic send_req(slrd_pkg::t_value lo, slrd_pkg::t_value hi);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.range_low  <= lo;
        req_ch.range_high <= hi;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    task automatic write_seed(slrd_pkg::t_value s);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_seed_we <= 1'b1;
        i_seed    <= s;
        @(negedge i_clk);
        i_seed_we <= 1'b0;
        load_seed(s);
    endtask

    initial begin : stimulus
        slrd_pkg::t_value lo;
        slrd_pkg::t_value hi;
        slrd_pkg::t_value s;
        int unsigned      ph;
        int unsigned      n;
        req_ch.valid      = 1'b0;
        req_ch.range_low  = '0;
        req_ch.range_high = '0;
        i_seed_we         = 1'b0;
        i_seed            = '0;
        i_rst_n           = 1'b0;
        // The state after reset is the same as that after a seed of zero.
        load_seed('0);
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].set_seed) begin
                write_seed(dir_rows[r].seed);
            end
            send_req(dir_rows[r].lo, dir_rows[r].hi);
            if (dir_rows[r].known) begin
                void'(draw_in_range(dir_rows[r].lo, dir_rows[r].hi));
                pending_values.push_back(dir_rows[r].want);
            end else begin
                pending_values.push_back(draw_in_range(dir_rows[r].lo, dir_rows[r].hi));
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1: s = $signed($urandom | 32'h1);
                2: s = '0;
                3: s = 32'sd1;
                4: s = $signed(32'h7FFF_FFFF);
                5: s = $signed(32'h8000_0001);
                6: s = $signed($urandom & 32'h7FFF_FFFE);
                default: s = '0;
            endcase
            if (ph != 0) begin
                write_seed(s);
            end
            no_gaps = (ph % 3 == 2);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick_range(lo, hi);
                send_req(lo, hi);
                pending_values.push_back(draw_in_range(lo, hi));
            end
        end

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending_values.size() == 0) begin
            $display("shuffled_lcg_range_draw_core_tb: PASS");
        end else begin
            $display("shuffled_lcg_range_draw_core_tb: FAIL");
        end
        $finish;
    end

    initial begin : result_side
        int unsigned      pause;
        slrd_pkg::t_value want;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            // A single long hold-off lets the core fill up and stall its input.
            if (values_seen == HOLD_AT) begin
                pause = HOLD_CYCLES;
            end else begin
                pause = no_gaps ? 0 : $urandom_range(0, 15);
            end
            @(negedge i_clk);
            if (pause != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (pause) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            values_seen++;
            if (pending_values.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result transaction: value %0d", rsp_ch.value);
                end
            end else begin
                want = pending_values.pop_front();
                if (rsp_ch.value !== want) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("value mismatch: expected %0d, actual %0d", want,
                                 rsp_ch.value);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", stall_cycles);
            $display("shuffled_lcg_range_draw_core_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
